// File: hdl/dsr_pkg.sv
package dsr_pkg;

   localparam int MAX_REQUESTS = 32;
   localparam int CYL_BITS     = 12;
   localparam int SUM_BITS     = 18;
   localparam int IDX_BITS     = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);
   localparam int VIS_BITS     = $clog2(MAX_REQUESTS + 3);
   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   // policy register codes; the two unused codes serve as FCFS
   localparam logic [2:0] POL_FCFS  = 3'd0;
   localparam logic [2:0] POL_SSTF  = 3'd1;
   localparam logic [2:0] POL_SCAN  = 3'd2;
   localparam logic [2:0] POL_CSCAN = 3'd3;
   localparam logic [2:0] POL_LOOK  = 3'd4;
   localparam logic [2:0] POL_CLOOK = 3'd5;

   // register indexes on the csr port
   localparam logic [1:0] REG_POLICY    = 2'd0;
   localparam logic [1:0] REG_START     = 2'd1;
   localparam logic [1:0] REG_MAX_CYL   = 2'd2;
   localparam logic [1:0] REG_THRESHOLD = 2'd3;

   typedef enum logic [2:0] {
      S_LOAD, S_PRE, S_SEL, S_MARK, S_WAIT
   } state_type;

   typedef enum logic [1:0] {
      PH_FIRST, PH_MARK_A, PH_MARK_B, PH_SECOND
   } phase_type;

   typedef enum logic [2:0] {
      MODE_PRE, MODE_FCFS, MODE_SSTF, MODE_ASC_UP, MODE_DESC_LO, MODE_ASC_LO, MODE_DESC_UP
   } mode_type;

   typedef struct packed {
      logic     load;
      logic     batch_start;
      logic     scan_start;
      logic     scan_run;
      mode_type mode;
      logic     visit;
      logic     marker;
      logic     marker_top;
      logic     batch_clear;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic up;
      logic other_nonempty;
      logic is_sstf;
      logic is_sweep;
      logic is_circ;
      logic has_marks;
      logic rsp_fire;
      logic rsp_last;
   } status_type;

endpackage

// File: hdl/dsr_datapath.sv
module dsr_datapath
   import dsr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [CYL_BITS-1:0] req_cylinder,
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [CYL_BITS-1:0] csr_wdata,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CYL_BITS-1:0] rsp_cylinder,
   output logic                rsp_ext,
   output logic [SUM_BITS-1:0] rsp_total,
   output logic                rsp_dropped,
   output logic                rsp_last
);

   logic [CYL_BITS-1:0] store_mem [MAX_REQUESTS];

   logic [2:0]          pol_cfg_ff, pol_cfg_in;
   logic [CYL_BITS-1:0] start_cfg_ff, start_cfg_in, top_cfg_ff, top_cfg_in;
   logic [CYL_BITS-1:0] thr_cfg_ff, thr_cfg_in;

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [MAX_REQUESTS-1:0] marks_ff, marks_in;

   logic [2:0]          pol_ff, pol_in;
   logic [CYL_BITS-1:0] bstart_ff, bstart_in, top_ff, top_in, head_ff, head_in;
   logic                up_ff, up_in, any_lo_ff, any_lo_in, any_hi_ff, any_hi_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;
   logic [VIS_BITS-1:0] visits_ff, visits_in;

   logic [CNT_BITS-1:0] scan_idx_ff, scan_idx_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic [CYL_BITS-1:0] rd_data_ff;
   logic                found_ff, found_in;
   logic [CYL_BITS-1:0] best_key_ff, best_key_in, best_val_ff, best_val_in;
   logic [IDX_BITS-1:0] best_idx_ff, best_idx_in;

   logic                rsp_valid_ff, rsp_valid_in, rsp_ext_ff, rsp_ext_in;
   logic                rsp_drop_ff, rsp_drop_in, rsp_last_ff, rsp_last_in;
   logic [CYL_BITS-1:0] rsp_cyl_ff, rsp_cyl_in;
   logic [SUM_BITS-1:0] rsp_tot_ff, rsp_tot_in;

   logic                issue, eligible, upper, take, is_circ, has_marks, other;
   logic [CYL_BITS-1:0] key, head_gap, visit_val, visit_d;
   logic [SUM_BITS:0]   sum_wide;
   logic [1:0]          n_marks;
   logic [VIS_BITS-1:0] total;
   logic                room;

   assign room      = count_ff < CNT_BITS'(MAX_REQUESTS);
   assign issue     = cmd.scan_run && (scan_idx_ff < count_ff);
   assign is_circ   = (pol_ff == POL_CSCAN) || (pol_ff == POL_CLOOK);
   assign has_marks = (pol_ff == POL_SCAN) || (pol_ff == POL_CSCAN);
   assign other     = up_ff ? any_lo_ff : any_hi_ff;

   always_comb begin
      n_marks = 2'd0;
      if (other && pol_ff == POL_SCAN) begin
         n_marks = 2'd1;
      end else if (other && pol_ff == POL_CSCAN) begin
         n_marks = 2'd2;
      end
   end
   assign total = VIS_BITS'(count_ff) + VIS_BITS'(n_marks);

   // candidate evaluation on the registered read
   assign upper    = rd_data_ff >= bstart_ff;
   assign head_gap = (rd_data_ff >= head_ff) ? rd_data_ff - head_ff : head_ff - rd_data_ff;

   always_comb begin
      eligible = 1'b0;
      key      = rd_data_ff;
      unique case (cmd.mode)
         MODE_PRE: begin
            eligible = 1'b0;
         end
         MODE_FCFS: begin
            eligible = !marks_ff[rd_idx_ff];
            key      = '0;
         end
         MODE_SSTF: begin
            eligible = !marks_ff[rd_idx_ff];
            key      = head_gap;
         end
         MODE_ASC_UP: begin
            eligible = !marks_ff[rd_idx_ff] && upper;
         end
         MODE_DESC_LO: begin
            eligible = !marks_ff[rd_idx_ff] && !upper;
            key      = ~rd_data_ff;
         end
         MODE_ASC_LO: begin
            eligible = !marks_ff[rd_idx_ff] && !upper;
         end
         MODE_DESC_UP: begin
            eligible = !marks_ff[rd_idx_ff] && upper;
            key      = ~rd_data_ff;
         end
         default: begin
            eligible = 1'b0;
         end
      endcase
   end
   assign take = rd_valid_ff && eligible && (!found_ff || key < best_key_ff);

   // head move of a visit
   always_comb begin
      visit_val = best_val_ff;
      if (cmd.marker) begin
         visit_val = cmd.marker_top ? top_ff : '0;
      end
   end
   assign visit_d  = (visit_val >= head_ff) ? visit_val - head_ff : head_ff - visit_val;
   assign sum_wide = {1'b0, sum_ff} + (SUM_BITS + 1)'(visit_d);

   always_comb begin
      pol_cfg_in   = pol_cfg_ff;
      start_cfg_in = start_cfg_ff;
      top_cfg_in   = top_cfg_ff;
      thr_cfg_in   = thr_cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_POLICY:    pol_cfg_in   = csr_wdata[2:0];
            REG_START:     start_cfg_in = csr_wdata;
            REG_MAX_CYL:   top_cfg_in   = csr_wdata;
            REG_THRESHOLD: thr_cfg_in   = csr_wdata;
            default:       pol_cfg_in   = pol_cfg_ff;
         endcase
      end

      count_in = count_ff;
      ovf_in   = ovf_ff;
      marks_in = marks_ff;
      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end

      pol_in    = pol_ff;
      bstart_in = bstart_ff;
      top_in    = top_ff;
      up_in     = up_ff;
      head_in   = head_ff;
      sum_in    = sum_ff;
      visits_in = visits_ff;
      any_lo_in = any_lo_ff;
      any_hi_in = any_hi_ff;
      if (cmd.batch_start) begin
         pol_in    = pol_cfg_ff;
         bstart_in = start_cfg_ff;
         top_in    = top_cfg_ff;
         up_in     = start_cfg_ff >= thr_cfg_ff;
         head_in   = start_cfg_ff;
         sum_in    = '0;
         visits_in = '0;
         any_lo_in = 1'b0;
         any_hi_in = 1'b0;
      end
      if (rd_valid_ff && cmd.mode == MODE_PRE) begin
         any_lo_in = any_lo_ff | !upper;
         any_hi_in = any_hi_ff | upper;
      end

      scan_idx_in = scan_idx_ff;
      rd_valid_in = issue;
      rd_idx_in   = scan_idx_ff[IDX_BITS-1:0];
      found_in    = found_ff | take;
      best_key_in = take ? key : best_key_ff;
      best_val_in = take ? rd_data_ff : best_val_ff;
      best_idx_in = take ? rd_idx_ff : best_idx_ff;
      if (issue) begin
         scan_idx_in = scan_idx_ff + 1'b1;
      end
      if (cmd.scan_start) begin
         scan_idx_in = '0;
         rd_valid_in = 1'b0;
         found_in    = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cyl_in   = rsp_cyl_ff;
      rsp_ext_in   = rsp_ext_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.visit || cmd.marker) begin
         sum_in       = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
         head_in      = visit_val;
         visits_in    = visits_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_cyl_in   = visit_val;
         rsp_ext_in   = cmd.marker;
         rsp_tot_in   = sum_in;
         rsp_drop_in  = ovf_ff;
         rsp_last_in  = (visits_ff + 1'b1) == total;
         if (cmd.visit) begin
            marks_in[best_idx_ff] = 1'b1;
         end
      end

      if (cmd.batch_clear) begin
         count_in = '0;
         ovf_in   = 1'b0;
         marks_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && room) begin
         store_mem[count_ff[IDX_BITS-1:0]] <= req_cylinder;
      end
      rd_data_ff <= store_mem[scan_idx_ff[IDX_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pol_cfg_ff   <= POL_FCFS;
         start_cfg_ff <= CYL_BITS'(53);
         top_cfg_ff   <= CYL_BITS'(199);
         thr_cfg_ff   <= CYL_BITS'(100);
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         marks_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= '0;
         visits_ff    <= '0;
         sum_ff       <= '0;
      end else begin
         pol_cfg_ff   <= pol_cfg_in;
         start_cfg_ff <= start_cfg_in;
         top_cfg_ff   <= top_cfg_in;
         thr_cfg_ff   <= thr_cfg_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         marks_ff     <= marks_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_idx_ff  <= scan_idx_in;
         visits_ff    <= visits_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      pol_ff      <= pol_in;
      bstart_ff   <= bstart_in;
      top_ff      <= top_in;
      up_ff       <= up_in;
      head_ff     <= head_in;
      any_lo_ff   <= any_lo_in;
      any_hi_ff   <= any_hi_in;
      rd_idx_ff   <= rd_idx_in;
      best_key_ff <= best_key_in;
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      rsp_cyl_ff  <= rsp_cyl_in;
      rsp_ext_ff  <= rsp_ext_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_drop_ff <= rsp_drop_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      status.scan_done      = (scan_idx_ff == count_ff) && !rd_valid_ff;
      status.found          = found_ff;
      status.up             = up_ff;
      status.other_nonempty = other;
      status.is_sstf        = pol_ff == POL_SSTF;
      status.is_sweep       = (pol_ff >= POL_SCAN) && (pol_ff <= POL_CLOOK);
      status.is_circ        = is_circ;
      status.has_marks      = has_marks;
      status.rsp_fire       = rsp_valid_ff && rsp_ready;
      status.rsp_last       = rsp_last_ff;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cylinder = rsp_cyl_ff;
   assign rsp_ext      = rsp_ext_ff;
   assign rsp_total    = rsp_tot_ff;
   assign rsp_dropped  = rsp_drop_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: hdl/dsr_control.sv
module dsr_control
   import dsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         phase_ff <= PH_FIRST;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.mode  = MODE_PRE;

      // selection rule of the current phase
      if (phase_ff == PH_FIRST) begin
         if (status.is_sstf) begin
            cmd.mode = MODE_SSTF;
         end else if (status.is_sweep) begin
            cmd.mode = status.up ? MODE_ASC_UP : MODE_DESC_LO;
         end else begin
            cmd.mode = MODE_FCFS;
         end
      end else if (status.is_circ) begin
         cmd.mode = status.up ? MODE_ASC_LO : MODE_DESC_UP;
      end else begin
         cmd.mode = status.up ? MODE_DESC_LO : MODE_ASC_UP;
      end

      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  cmd.batch_start = 1'b1;
                  cmd.scan_start  = 1'b1;
                  state_in        = S_PRE;
               end
            end
         end
         S_PRE: begin
            cmd.mode     = MODE_PRE;
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               cmd.scan_start = 1'b1;
               phase_in       = PH_FIRST;
               state_in       = S_SEL;
            end
         end
         S_SEL: begin
            cmd.scan_run = 1'b1;
            if (status.scan_done) begin
               if (status.found) begin
                  cmd.visit = 1'b1;
                  state_in  = S_WAIT;
               end else if (status.has_marks && status.other_nonempty) begin
                  phase_in = PH_MARK_A;
                  state_in = S_MARK;
               end else begin
                  phase_in       = PH_SECOND;
                  cmd.scan_start = 1'b1;
               end
            end
         end
         S_MARK: begin
            cmd.marker     = 1'b1;
            cmd.marker_top = (phase_ff == PH_MARK_A) ? status.up : !status.up;
            state_in       = S_WAIT;
         end
         S_WAIT: begin
            if (status.rsp_fire) begin
               if (status.rsp_last) begin
                  cmd.batch_clear = 1'b1;
                  state_in        = S_LOAD;
               end else if (phase_ff == PH_MARK_A && status.is_circ) begin
                  phase_in = PH_MARK_B;
                  state_in = S_MARK;
               end else begin
                  if (phase_ff == PH_MARK_A || phase_ff == PH_MARK_B) begin
                     phase_in = PH_SECOND;
                  end
                  cmd.scan_start = 1'b1;
                  state_in       = S_SEL;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

endmodule

// File: hdl/disk_request_scheduler.sv
// Disk request scheduler.
// req_ channel: one cylinder request a beat; tlast marks the final request of a
//   batch. Up to MAX_REQUESTS are stored, further ones are discarded and flagged.
// rsp_ channel: the service order of the batch, one head visit a beat, with the
//   running head movement (saturating); tlast marks the final visit.
// csr_ port: policy, start position, max cylinder, upward threshold; write only
//   between batches.
// Loading takes one beat a cycle. After the last beat a pre-scan notes whether
//   any request lies on the upper and on the lower side. Each visit then costs
//   one scan of the store through its single read port, whose final step commits
//   the visit, and then waits until the beat is taken; sweep markers need no
//   scan, and a side change costs one more scan.
// A result beat waits in the output register while the receiver stalls; the
//   next selection starts only after it is taken, and no request is taken
//   until the whole batch is out.
// Reset (synchronous) empties the batch, drops any pending beat and restores the
//   register defaults: FCFS, start 53, max cylinder 199, threshold 100.
module disk_request_scheduler
   import dsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] cylinder, rest zero
   input  logic        req_tlast,   // last_request
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [11:0] served_cylinder, [29:12] total_movement
   output logic [1:0]  rsp_tuser,   // [0] is_extremity, [1] dropped
   output logic        rsp_tlast,   // last_visit
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [11:0] csr_wdata
);

   cmd_type             cmd;
   status_type          status;
   logic [CYL_BITS-1:0] rsp_cyl;
   logic [SUM_BITS-1:0] rsp_tot;
   logic                rsp_ext, rsp_drop;

   dsr_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   dsr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_cylinder (req_tdata[CYL_BITS-1:0]),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_cylinder (rsp_cyl),
      .rsp_ext      (rsp_ext),
      .rsp_total    (rsp_tot),
      .rsp_dropped  (rsp_drop),
      .rsp_last     (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_tot, rsp_cyl};
   assign rsp_tuser = {rsp_drop, rsp_ext};

endmodule

// File: hdl/dsr_checker.sv
module dsr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // pending beat is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat withdrawn");

   a_no_load_during_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while result pending");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

   // a sweep marker always has requests after it
   a_marker_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tlast)
      else $error("marker ends a batch");

   a_reload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not ready for next batch");

endmodule

bind disk_request_scheduler dsr_checker u_dsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: sim/tb_disk_request_scheduler.sv
module tb_disk_request_scheduler;
   import dsr_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [11:0] cylinder
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [11:0] served_cylinder, [29:12] total_movement
   logic [1:0]  rsp_tuser;   // [0] is_extremity, [1] dropped
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [11:0] csr_wdata;

   disk_request_scheduler DUT (.*);

   // one visit of the head as it leaves the block
   typedef struct packed {
      logic [11:0] cyl;
      logic        ext;
      logic [17:0] moved;
      logic        dropped;
      logic        last;
   } visit_t;

   // directed stimulus row; exp_cyl / exp_moved are only checked where chk is set
   typedef struct {
      logic [11:0] cyl;
      logic        last;
      logic        chk;
      logic [11:0] exp_cyl;
      logic [17:0] exp_moved;
   } stim_row_t;

   visit_t      visit_queue[$];
   logic        pinned_queue[$];   // per visit: a typed value was checked
   logic [11:0] pinned_cyl[$];
   logic [17:0] pinned_moved[$];

   // shadow registers and batch
   logic [2:0]  m_policy;
   logic [11:0] m_start, m_top, m_thresh;
   logic [11:0] m_store[$];
   logic        m_over;
   logic [11:0] m_head;
   logic [17:0] m_sum;

   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

   // append one visit to the expected order
   task automatic add_visit(input logic [11:0] c, input logic ext);
      logic [18:0] s;
      visit_t v;
      begin
         s = m_sum + ((c >= m_head) ? c - m_head : m_head - c);
         m_sum = (s > 19'(SUM_MAX)) ? SUM_MAX : s[17:0];
         m_head = c;
         v.cyl = c; v.ext = ext; v.moved = m_sum; v.dropped = m_over; v.last = 1'b0;
         visit_queue.push_back(v);
         pinned_queue.push_back(1'b0);
         pinned_cyl.push_back('0);
         pinned_moved.push_back('0);
      end
   endtask

   // work out the service order of the stored batch
   task automatic schedule_batch();
      logic [11:0] srt[$];
      logic        taken[$];
      int n, split, best, bd, d, first;
      logic up, circ, marks;
      visit_t v;
      begin
         n = m_store.size();
         m_head = m_start;
         m_sum = '0;
         first = visit_queue.size();
         if (m_policy == POL_SSTF) begin
            for (int i = 0; i < n; i++) taken.push_back(1'b0);
            for (int j = 0; j < n; j++) begin
               bd = 1 << 20; best = 0;
               for (int i = 0; i < n; i++) begin
                  if (taken[i]) continue;
                  d = (m_store[i] >= m_head) ? m_store[i] - m_head : m_head - m_store[i];
                  if (d < bd) begin
                     bd = d; best = i;
                  end
               end
               taken[best] = 1'b1;
               add_visit(m_store[best], 1'b0);
            end
         end else if (m_policy >= POL_SCAN && m_policy <= POL_CLOOK) begin
            srt = m_store;
            srt.sort();
            split = n;
            for (int i = 0; i < n; i++)
               if (srt[i] >= m_start) begin
                  split = i; break;
               end
            up    = (m_start >= m_thresh);
            circ  = (m_policy == POL_CSCAN || m_policy == POL_CLOOK);
            marks = (m_policy == POL_SCAN || m_policy == POL_CSCAN);
            if (up) begin
               for (int i = split; i < n; i++) add_visit(srt[i], 1'b0);
               if (marks && split > 0) begin
                  add_visit(m_top, 1'b1);
                  if (circ) add_visit('0, 1'b1);
               end
               if (circ) for (int i = 0; i < split; i++) add_visit(srt[i], 1'b0);
               else for (int i = split; i > 0; i--) add_visit(srt[i-1], 1'b0);
            end else begin
               for (int i = split; i > 0; i--) add_visit(srt[i-1], 1'b0);
               if (marks && split < n) begin
                  add_visit('0, 1'b1);
                  if (circ) add_visit(m_top, 1'b1);
               end
               if (circ) for (int i = n; i > split; i--) add_visit(srt[i-1], 1'b0);
               else for (int i = split; i < n; i++) add_visit(srt[i], 1'b0);
            end
         end else begin
            for (int i = 0; i < n; i++) add_visit(m_store[i], 1'b0);
         end
         if (visit_queue.size() > first) begin
            v = visit_queue[$];
            v.last = 1'b1;
            visit_queue[$] = v;
         end
         m_store.delete();
         m_over = 1'b0;
         m_head = m_start;
      end
   endtask

   task automatic take_request(input logic [11:0] c, input logic last);
      begin
         if (m_store.size() < MAX_REQUESTS) m_store.push_back(c);
         else m_over = 1'b1;
         if (last) schedule_batch();
      end
   endtask

   // one beat on req_, with the sender's idle gaps; tvalid is dropped by drain()
   task automatic send_beat(input logic [11:0] c, input logic last);
      begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {4'd0, c};
         req_tlast  <= last;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         take_request(c, last);
         @(negedge clock);
      end
   endtask

   // one register write; write_all() drops the enable after the last one
   task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
      begin
         csr_we <= 1'b1; csr_addr <= idx; csr_wdata <= val;
         @(negedge clock);
         case (idx)
            REG_POLICY:    m_policy = val[2:0];
            REG_START:     begin m_start = val; m_head = val; end
            REG_MAX_CYL:   m_top = val;
            default:       m_thresh = val;
         endcase
      end
   endtask

   task automatic write_all(input logic [2:0] pol, input logic [11:0] st,
                            input logic [11:0] top, input logic [11:0] th);
      begin
         write_reg(REG_POLICY, {9'd0, pol});
         write_reg(REG_START, st);
         write_reg(REG_MAX_CYL, top);
         write_reg(REG_THRESHOLD, th);
         csr_we <= 1'b0;
      end
   endtask

   // idle point: everything out, then a margin for a batch still settling
   task automatic drain();
      int guard;
      begin
         req_tvalid <= 1'b0;
         guard = 0;
         while (visit_queue.size() != 0 && guard < 400000) begin
            @(negedge clock);
            guard++;
         end
         repeat (50) @(negedge clock);
      end
   endtask

   // a random batch: mostly small, now and then past capacity
   task automatic random_batch(output int sent);
      int n;
      logic [11:0] c;
      begin
         case ($urandom_range(9))
            0:       n = MAX_REQUESTS + $urandom_range(1, 3);
            1:       n = 1;
            default: n = $urandom_range(2, 8);
         endcase
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
               0:       c = 12'($urandom_range(4095));
               1:       c = 12'($urandom_range(255));
               2:       c = (m_start > 40) ? m_start - 12'($urandom_range(40)) : m_start;
               default: c = (m_start < 4055) ? m_start + 12'($urandom_range(40)) : m_start;
            endcase
            send_beat(c, i == n - 1);
         end
         sent = n;
      end
   endtask

   // receiver side: random stalls, compare each beat with the oldest visit
   always @(posedge clock) begin
      visit_t exp_v, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.cyl = rsp_tdata[11:0]; got.moved = rsp_tdata[29:12];
         got.ext = rsp_tuser[0]; got.dropped = rsp_tuser[1]; got.last = rsp_tlast;
         if (visit_queue.size() == 0) begin
            $display("%0t: unexpected visit, expected none, actual %p", $time, got);
            errors++;
         end else begin
            exp_v = visit_queue.pop_front();
            if (pinned_queue.pop_front()) begin
               exp_v.cyl = pinned_cyl[0]; exp_v.moved = pinned_moved[0];
            end
            void'(pinned_cyl.pop_front());
            void'(pinned_moved.pop_front());
            if (got !== exp_v) begin
               $display("%0t: visit mismatch, expected %p, actual %p", $time, exp_v, got);
               errors++;
            end
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   // directed rows: reset defaults, extremes, the textbook queue for each policy
   stim_row_t rows[] = '{
      '{12'd98,   1'b1, 1'b1, 12'd98,   18'd45},   // FCFS from 53
      '{12'd0,    1'b0, 1'b0, 12'd0,    18'd0},
      '{12'd4095, 1'b0, 1'b0, 12'd0,    18'd0},
      '{12'd53,   1'b1, 1'b0, 12'd0,    18'd0},
      '{12'd183,  1'b0, 1'b0, 12'd0,    18'd0},
      '{12'd37,   1'b0, 1'b0, 12'd0,    18'd0},
      '{12'd122,  1'b0, 1'b0, 12'd0,    18'd0},
      '{12'd14,   1'b0, 1'b0, 12'd0,    18'd0},
      '{12'd124,  1'b0, 1'b0, 12'd0,    18'd0},
      '{12'd65,   1'b0, 1'b0, 12'd0,    18'd0},
      '{12'd67,   1'b1, 1'b0, 12'd0,    18'd0}
   };

   initial begin
      int sent, n_batch, phase;
      logic [2:0] pol;
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0; csr_addr = REG_POLICY; csr_wdata = '0;
      m_policy = POL_FCFS; m_start = 12'd53; m_top = 12'd199; m_thresh = 12'd100;
      m_over = 1'b0; m_head = 12'd53; m_sum = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default registers: first row's result pinned
      for (int r = 0; r < rows.size(); r++) begin
         sent = visit_queue.size();
         send_beat(rows[r].cyl, rows[r].last);
         if (rows[r].chk) begin
            pinned_queue[sent] = 1'b1;
            pinned_cyl[sent] = rows[r].exp_cyl;
            pinned_moved[sent] = rows[r].exp_moved;
         end
      end
      drain();

      // the textbook queue under each policy, direction alternating between policies, plus codes 6 and 7
      for (int p = 0; p < 8; p++) begin
         write_all(p[2:0], (p % 2) ? 12'd53 : 12'd150, 12'd199, 12'd100);
         for (int r = 4; r < rows.size(); r++) send_beat(rows[r].cyl, rows[r].last);
         drain();
      end

      // store overflow, long head moves, register extremes
      write_all(POL_SCAN, 12'd4095, 12'd4095, 12'd0);
      for (int i = 0; i < MAX_REQUESTS + 2; i++)
         send_beat((i % 2) ? 12'd4095 : 12'd0, i == MAX_REQUESTS + 1);
      drain();
      write_all(POL_CSCAN, 12'd0, 12'd1, 12'd4095);
      for (int i = 0; i < 4; i++) send_beat(12'd4095 - i, i == 3);
      drain();
      write_all(POL_FCFS, 12'd0, 12'd199, 12'd100);
      for (int i = 0; i < MAX_REQUESTS; i++)
         send_beat((i % 2) ? 12'd4095 : 12'd0, i == MAX_REQUESTS - 1);
      drain();

      // random batches across the idling phases
      sent = 0; phase = 0;
      while (sent < 85 || phase < 4) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         pol = 3'($urandom_range(7));
         write_all(pol, 12'($urandom_range(4095)), 12'($urandom_range(1, 4095)),
                   ($urandom_range(3) == 0) ? 12'($urandom_range(4095)) : 12'd2048);
         for (int b = 0; b < 3; b++) begin
            random_batch(n_batch);
            sent += n_batch;
         end
         drain();
         phase++;
      end

      drain();
      if (errors == 0 && visit_queue.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
